// ===== design/atapio_pkg.sv =====
// ----------------------------------------------------------------------------
// atapio_pkg
// Shared types, register offsets, command codes and helpers for the ATA PIO
// LBA28 transfer sequencer.
// ----------------------------------------------------------------------------
package atapio_pkg;

    localparam int SECTOR_WORDS = 256;
    localparam int DELAY_READS  = 4;
    localparam int MAX_RES      = 6;

    localparam int WORDS_W = $clog2(SECTOR_WORDS + 1);
    localparam int DELAY_W = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);
    localparam int POLL_W  = 17;

    localparam logic [POLL_W-1:0] POLL_LIMIT_RST = POLL_W'(100000);

    // item selector
    localparam logic [1:0] MODE_START_RD = 2'd0;
    localparam logic [1:0] MODE_START_WR = 2'd1;
    localparam logic [1:0] MODE_RESP     = 2'd2;
    localparam logic [1:0] MODE_SRC_WORD = 2'd3;

    // result kinds
    localparam logic [2:0] K_BWR  = 3'd0;
    localparam logic [2:0] K_BRD  = 3'd1;
    localparam logic [2:0] K_WWR  = 3'd2;
    localparam logic [2:0] K_WRD  = 3'd3;
    localparam logic [2:0] K_DATA = 3'd4;
    localparam logic [2:0] K_DONE = 3'd5;

    // outcomes
    localparam logic [1:0] OUT_OK      = 2'd0;
    localparam logic [1:0] OUT_DEV_ERR = 2'd1;
    localparam logic [1:0] OUT_TIMEOUT = 2'd2;

    // task file register offsets
    localparam logic [15:0] REG_DATA   = 16'd0;
    localparam logic [15:0] REG_COUNT  = 16'd2;
    localparam logic [15:0] REG_LBA0   = 16'd3;
    localparam logic [15:0] REG_LBA1   = 16'd4;
    localparam logic [15:0] REG_LBA2   = 16'd5;
    localparam logic [15:0] REG_DEVSEL = 16'd6;
    localparam logic [15:0] REG_CMD    = 16'd7;

    localparam logic [7:0] DEV_LBA_MODE = 8'hF0;
    localparam logic [7:0] CMD_READ     = 8'h20;
    localparam logic [7:0] CMD_WRITE    = 8'h30;
    localparam logic [7:0] CMD_FLUSH    = 8'hE7;

    // status bits
    localparam int ST_ERR = 0;
    localparam int ST_DRQ = 3;
    localparam int ST_DF  = 5;
    localparam int ST_BSY = 7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETUP_DELAY,
        PH_KICK,
        PH_POLL,
        PH_RD_WORD,
        PH_WR_WAIT,
        PH_SEC_DELAY,
        PH_FLUSH
    } phase_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [27:0] lba;
        logic [7:0]  sector_count;
        logic [15:0] port_base;
        logic [15:0] read_value;
        logic [15:0] source_word;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] bus_address;
        logic [15:0] bus_write_data;
        logic [15:0] data_word;
        logic [1:0]  outcome;
    } res_t;

    typedef res_t [MAX_RES-1:0] res_list_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        res_list_t        list;
    } res_batch_t;

    typedef struct packed {
        phase_t              phase;
        logic                is_write;
        logic [27:0]         lba;
        logic [15:0]         port;
        logic [7:0]          sectors_left;
        logic [DELAY_W-1:0]  delay_done;
        logic [POLL_W-1:0]   polls_left;
        logic [WORDS_W-1:0]  words_done;
    } seq_state_t;

    function automatic res_t mk_res(
        input logic [2:0]  kind,
        input logic [15:0] addr,
        input logic [15:0] wdata,
        input logic [15:0] dword,
        input logic [1:0]  outc
    );
        res_t r;
        r.kind           = kind;
        r.bus_address    = addr;
        r.bus_write_data = wdata;
        r.data_word      = dword;
        r.outcome        = outc;
        return r;
    endfunction

endpackage

// ===== design/atapio_skid.sv =====
// ----------------------------------------------------------------------------
// atapio_skid
// Two-entry input buffer; tready comes straight from a flop.
// ----------------------------------------------------------------------------
module atapio_skid
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  atapio_pkg::item_t  in_item,
    output logic               out_valid,
    input  logic               out_take,
    output atapio_pkg::item_t  out_item
);
    import atapio_pkg::*;

    logic  main_valid_reg, main_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    item_t main_reg, main_next;
    item_t skid_reg, skid_next;
    logic  in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_item  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = in_item;
                main_valid_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_next       = in_item;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty main entry");

endmodule

// ===== design/atapio_seq.sv =====
// ----------------------------------------------------------------------------
// atapio_seq
// Transfer state and the per-item step: one item in, up to six bus accesses
// or status results out, decided in a single pass.
// ----------------------------------------------------------------------------
module atapio_seq
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          consume,
    input  atapio_pkg::item_t             item,
    input  logic [atapio_pkg::POLL_W-1:0] poll_limit,
    output atapio_pkg::res_batch_t        batch
);
    import atapio_pkg::*;

    seq_state_t st_reg, st_next;

    always_comb
    begin
        logic [CNT_W-1:0]   n;
        logic               do_setup;
        logic               do_begin;
        logic               do_end_xfer;
        logic               do_sec_end;
        logic               do_sec_done;
        logic [7:0]         stat;
        logic [WORDS_W-1:0] words_inc;

        st_next     = st_reg;
        batch.list  = '0;
        n           = '0;
        do_setup    = 1'b0;
        do_begin    = 1'b0;
        do_end_xfer = 1'b0;
        do_sec_end  = 1'b0;
        do_sec_done = 1'b0;
        stat        = item.read_value[7:0];
        words_inc   = st_reg.words_done + 1'b1;

        unique case (item.mode)
            MODE_START_RD, MODE_START_WR:
            begin
                if (st_reg.phase == PH_IDLE)
                begin
                    st_next.is_write     = (item.mode == MODE_START_WR);
                    st_next.lba          = item.lba;
                    st_next.sectors_left = item.sector_count;
                    st_next.port         = item.port_base;
                    st_next.delay_done   = '0;
                    st_next.words_done   = '0;
                    batch.list[n] = mk_res(K_BWR, item.port_base + REG_DEVSEL,
                        {8'h00, DEV_LBA_MODE | {4'h0, item.lba[27:24]}}, '0, OUT_OK);
                    n = n + 1'b1;
                    if (DELAY_READS == 0)
                    begin
                        do_setup = 1'b1;
                    end
                    else
                    begin
                        st_next.delay_done = DELAY_W'(1);
                        batch.list[n] = mk_res(K_BRD, item.port_base + REG_CMD,
                            '0, '0, OUT_OK);
                        n = n + 1'b1;
                        st_next.phase = PH_SETUP_DELAY;
                    end
                end
            end
            MODE_RESP:
            begin
                unique case (st_reg.phase)
                    PH_SETUP_DELAY:
                    begin
                        if (st_reg.delay_done < DELAY_W'(DELAY_READS))
                        begin
                            st_next.delay_done = st_reg.delay_done + 1'b1;
                            batch.list[n] = mk_res(K_BRD, st_reg.port + REG_CMD,
                                '0, '0, OUT_OK);
                            n = n + 1'b1;
                        end
                        else
                        begin
                            do_setup = 1'b1;
                        end
                    end
                    PH_KICK:
                    begin
                        do_begin = 1'b1;
                    end
                    PH_POLL:
                    begin
                        if (stat[ST_ERR] || stat[ST_DF])
                        begin
                            batch.list[n] = mk_res(K_DONE, '0, '0, '0, OUT_DEV_ERR);
                            n = n + 1'b1;
                            st_next.phase = PH_IDLE;
                        end
                        else if (!stat[ST_BSY] && stat[ST_DRQ])
                        begin
                            st_next.words_done = '0;
                            if (st_reg.is_write)
                            begin
                                st_next.phase = PH_WR_WAIT;
                            end
                            else
                            begin
                                batch.list[n] = mk_res(K_WRD, st_reg.port + REG_DATA,
                                    '0, '0, OUT_OK);
                                n = n + 1'b1;
                                st_next.phase = PH_RD_WORD;
                            end
                        end
                        else
                        begin
                            st_next.polls_left = st_reg.polls_left - 1'b1;
                            if (st_next.polls_left == '0)
                            begin
                                batch.list[n] = mk_res(K_DONE, '0, '0, '0, OUT_TIMEOUT);
                                n = n + 1'b1;
                                st_next.phase = PH_IDLE;
                            end
                            else
                            begin
                                batch.list[n] = mk_res(K_BRD, st_reg.port + REG_CMD,
                                    '0, '0, OUT_OK);
                                n = n + 1'b1;
                            end
                        end
                    end
                    PH_RD_WORD:
                    begin
                        batch.list[n] = mk_res(K_DATA, '0, '0, item.read_value, OUT_OK);
                        n = n + 1'b1;
                        st_next.words_done = words_inc;
                        if (words_inc < WORDS_W'(SECTOR_WORDS))
                        begin
                            batch.list[n] = mk_res(K_WRD, st_reg.port + REG_DATA,
                                '0, '0, OUT_OK);
                            n = n + 1'b1;
                        end
                        else
                        begin
                            do_sec_end = 1'b1;
                        end
                    end
                    PH_SEC_DELAY:
                    begin
                        if (st_reg.delay_done < DELAY_W'(DELAY_READS))
                        begin
                            st_next.delay_done = st_reg.delay_done + 1'b1;
                            batch.list[n] = mk_res(K_BRD, st_reg.port + REG_CMD,
                                '0, '0, OUT_OK);
                            n = n + 1'b1;
                        end
                        else
                        begin
                            do_sec_done = 1'b1;
                        end
                    end
                    PH_FLUSH:
                    begin
                        if (stat[ST_BSY])
                        begin
                            batch.list[n] = mk_res(K_BRD, st_reg.port + REG_CMD,
                                '0, '0, OUT_OK);
                            n = n + 1'b1;
                        end
                        else
                        begin
                            batch.list[n] = mk_res(K_DONE, '0, '0, '0, OUT_OK);
                            n = n + 1'b1;
                            st_next.phase = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        // idle or waiting for source words: response dropped
                    end
                endcase
            end
            MODE_SRC_WORD:
            begin
                if (st_reg.phase == PH_WR_WAIT)
                begin
                    batch.list[n] = mk_res(K_WWR, st_reg.port + REG_DATA,
                        item.source_word, '0, OUT_OK);
                    n = n + 1'b1;
                    st_next.words_done = words_inc;
                    if (words_inc >= WORDS_W'(SECTOR_WORDS))
                        do_sec_end = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // end of a sector's data: settle delay, then next sector
        if (do_sec_end)
        begin
            if (DELAY_READS == 0)
            begin
                do_sec_done = 1'b1;
            end
            else
            begin
                st_next.delay_done = DELAY_W'(1);
                batch.list[n] = mk_res(K_BRD, st_reg.port + REG_CMD, '0, '0, OUT_OK);
                n = n + 1'b1;
                st_next.phase = PH_SEC_DELAY;
            end
        end

        if (do_sec_done)
        begin
            st_next.sectors_left = st_reg.sectors_left - 1'b1;
            do_begin = 1'b1;
        end

        // task file load and command
        if (do_setup)
        begin
            batch.list[n] = mk_res(K_BWR, st_next.port + REG_COUNT,
                {8'h00, st_next.sectors_left}, '0, OUT_OK);
            n = n + 1'b1;
            batch.list[n] = mk_res(K_BWR, st_next.port + REG_LBA0,
                {8'h00, st_next.lba[7:0]}, '0, OUT_OK);
            n = n + 1'b1;
            batch.list[n] = mk_res(K_BWR, st_next.port + REG_LBA1,
                {8'h00, st_next.lba[15:8]}, '0, OUT_OK);
            n = n + 1'b1;
            batch.list[n] = mk_res(K_BWR, st_next.port + REG_LBA2,
                {8'h00, st_next.lba[23:16]}, '0, OUT_OK);
            n = n + 1'b1;
            batch.list[n] = mk_res(K_BWR, st_next.port + REG_CMD,
                {8'h00, st_next.is_write ? CMD_WRITE : CMD_READ}, '0, OUT_OK);
            n = n + 1'b1;
            // list full, or zero-count write: wait for one more response
            if ((n >= CNT_W'(MAX_RES)) || (st_next.is_write && st_next.sectors_left == '0))
                st_next.phase = PH_KICK;
            else
                do_begin = 1'b1;
        end

        if (do_begin)
        begin
            if (st_next.sectors_left == '0)
            begin
                do_end_xfer = 1'b1;
            end
            else if (poll_limit == '0)
            begin
                batch.list[n] = mk_res(K_DONE, '0, '0, '0, OUT_TIMEOUT);
                n = n + 1'b1;
                st_next.phase = PH_IDLE;
            end
            else
            begin
                st_next.polls_left = poll_limit;
                batch.list[n] = mk_res(K_BRD, st_next.port + REG_CMD, '0, '0, OUT_OK);
                n = n + 1'b1;
                st_next.phase = PH_POLL;
            end
        end

        if (do_end_xfer)
        begin
            if (st_next.is_write)
            begin
                batch.list[n] = mk_res(K_BWR, st_next.port + REG_CMD,
                    {8'h00, CMD_FLUSH}, '0, OUT_OK);
                n = n + 1'b1;
                batch.list[n] = mk_res(K_BRD, st_next.port + REG_CMD, '0, '0, OUT_OK);
                n = n + 1'b1;
                st_next.phase = PH_FLUSH;
            end
            else
            begin
                batch.list[n] = mk_res(K_DONE, '0, '0, '0, OUT_OK);
                n = n + 1'b1;
                st_next.phase = PH_IDLE;
            end
        end

        batch.cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{phase: PH_IDLE, default: '0};
        end
        else if (consume)
        begin
            st_reg <= st_next;
        end
    end

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && batch.cnt != '0 &&
         batch.list[IDX_W'(batch.cnt - 1'b1)].kind == K_DONE)
        |=> (st_reg.phase == PH_IDLE))
        else $error("finished result without return to idle");

    a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        consume |-> (batch.cnt <= CNT_W'(MAX_RES)))
        else $error("result batch overflow");

endmodule

// ===== design/atapio_outq.sv =====
// ----------------------------------------------------------------------------
// atapio_outq
// Result register: holds one item's batch and sends it out a beat at a time.
// ----------------------------------------------------------------------------
module atapio_outq
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  atapio_pkg::res_batch_t batch,
    output logic                   free,
    output logic                   out_valid,
    input  logic                   out_ready,
    output atapio_pkg::res_t       out_res,
    output logic                   out_last
);
    import atapio_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    res_list_t        list_reg;
    logic             beat;

    assign out_valid = (cnt_reg != '0);
    assign out_res   = list_reg[idx_reg];
    assign out_last  = (CNT_W'(idx_reg) == cnt_reg - 1'b1);
    assign beat      = out_valid && out_ready;
    assign free      = !out_valid || (beat && out_last);

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (beat)
        begin
            if (out_last)
                cnt_next = '0;
            else
                idx_next = idx_reg + 1'b1;
        end
        if (load)
        begin
            cnt_next = batch.cnt;
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            list_reg <= batch.list;
    end

    a_idx_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CNT_W'(idx_reg) < cnt_reg))
        else $error("read index past end of batch");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("batch loaded over undelivered results");

endmodule

// ===== design/ata_pio_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// ata_pio_transfer_sequencer
// Host-side ATA PIO LBA28 transfer sequencer.
// ----------------------------------------------------------------------------
// Use: the s_axis channel carries control beats. tuser picks the beat type:
// start read, start write, bus read response (value of the last read issued
// on m_axis) or one source word for a write. The m_axis channel returns bus
// accesses (byte/word writes and reads at port base + register offset),
// sector data words and a finished beat with the outcome. Every input beat
// gives zero to six result beats; tlast marks the last one of each input.
// cfg_we/cfg_wdata set the per-sector poll limit; write it only when idle.
//
// The first result beat of an input beat passes the input buffer, then the
// result register. Throughput: one input beat per cycle while each gives at
// most one result and m_axis_tready is high; a beat with k results holds the
// output until all k are taken, as the result register drains one entry per cycle while m_axis_tready is high.
// Reset: sequencer idle, poll limit 100000, both buffers empty.
// Stall: with m_axis_tready low the result register holds, the input buffer
// fills (up to two beats), then s_axis_tready drops.
// ----------------------------------------------------------------------------
module ata_pio_transfer_sequencer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [27:0] lba, [35:28] sector_count, [51:36] port_base,
    // [67:52] read_value, [83:68] source_word, [87:84] zero
    input  logic [87:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] bus_address, [31:16] bus_write_data, [47:32] data_word,
    // [49:48] outcome, [55:50] zero
    output logic [55:0] m_axis_tdata,
    // [2:0] kind
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,

    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata
);
    import atapio_pkg::*;

    logic [POLL_W-1:0] poll_limit_reg;
    item_t             in_item;
    item_t             cur_item;
    logic              cur_valid;
    logic              res_free;
    logic              consume;
    res_batch_t        batch;
    res_t              out_res;

    // unpack the input beat
    assign in_item.mode         = s_axis_tuser;
    assign in_item.lba          = s_axis_tdata[27:0];
    assign in_item.sector_count = s_axis_tdata[35:28];
    assign in_item.port_base    = s_axis_tdata[51:36];
    assign in_item.read_value   = s_axis_tdata[67:52];
    assign in_item.source_word  = s_axis_tdata[83:68];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            poll_limit_reg <= POLL_LIMIT_RST;
        else if (cfg_we)
            poll_limit_reg <= cfg_wdata;
    end

    atapio_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (cur_valid),
        .out_take  (consume),
        .out_item  (cur_item)
    );

    // an item is stepped once the result register can take its batch
    assign consume = cur_valid && res_free;

    atapio_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .consume    (consume),
        .item       (cur_item),
        .poll_limit (poll_limit_reg),
        .batch      (batch)
    );

    // items that give no result just update state
    atapio_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (consume && (batch.cnt != '0)),
        .batch     (batch),
        .free      (res_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {6'd0, out_res.outcome, out_res.data_word,
                           out_res.bus_write_data, out_res.bus_address};

endmodule
